@@ hdl/totp_code_verifier_top_defines.svh @@
// assertion macros for the totp code verifier
// used by totp_code_verifier_top, needs a clock and reset in scope
`ifndef TOTP_CODE_VERIFIER_TOP_DEFINES_SVH
`define TOTP_CODE_VERIFIER_TOP_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define TOTP_CV_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TOTP_CV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/totp_cv_pkg.sv @@
// shared types and constants of the totp code verifier
// no dependencies
package totp_cv_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_KEY_HIGH   = 2'd0;
   localparam logic [1:0] CSR_KEY_MIDDLE = 2'd1;
   localparam logic [1:0] CSR_KEY_LOW    = 2'd2;
   localparam logic [1:0] CSR_KEY_LENGTH = 2'd3;

   localparam int          STORED_KEY_BYTES = 20;
   localparam logic [4:0]  KEY_LENGTH_RESET = 5'd20;
   localparam logic [4:0]  STEP_SECONDS     = 5'd30;
   localparam logic [20:0] CODE_MODULUS     = 21'd1000000;
   localparam logic [7:0]  IPAD_BYTE        = 8'h36;
   localparam logic [7:0]  OPAD_BYTE        = 8'h5C;
   localparam logic [7:0]  PAD_MARK         = 8'h80;
   localparam logic [63:0] MSG_BIT_LEN      = 64'd576;
   localparam logic [63:0] DIGEST_BIT_LEN   = 64'd672;

   // byte-wise division by 30: quotient digit is (v * ceil(2^20 / 30)) >> 20
   localparam logic [15:0] DIV_RECIP   = 16'd34953;
   // 2^20 mod 10^6, used to fold the high bits down
   localparam logic [15:0] FOLD_WEIGHT = 16'd48576;

   localparam int TIME_DIGITS = 8;
   localparam int FOLD_STEPS  = 4;
   localparam int SHA_ROUNDS  = 80;

   // time window codes
   localparam logic [1:0] WIN_PREV = 2'd0;
   localparam logic [1:0] WIN_CUR  = 2'd1;
   localparam logic [1:0] WIN_NEXT = 2'd2;

   localparam logic [0:4][31:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                           32'h10325476, 32'hC3D2E1F0};
   localparam logic [0:3][31:0] SHA1_K  = {32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                           32'hCA62C1D6};

   typedef enum logic [1:0] {BLK_IPAD, BLK_MSG, BLK_OPAD, BLK_DIGEST} blk_sel_type;

   typedef struct packed {
      logic        capture;
      logic        div_step;
      logic        save_step;
      logic        set_msg;
      logic [1:0]  window;
      logic        hash_init;
      logic        load_block;
      blk_sel_type blk_sel;
      logic        round;
      logic [1:0]  phase;
      logic        finish;
      logic        save_inner;
      logic        load_trunc;
      logic        check;
   } dp_cmd_type;

   typedef struct packed {
      logic match;
      logic six_digits;
   } dp_status_type;

endpackage

@@ hdl/totp_cv_datapath.sv @@
// datapath: byte-wise divider, modulo fold, sha-1 round engine, hmac block builder
// depends on totp_cv_pkg
module totp_cv_datapath
   import totp_cv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  logic [159:0]  key_bytes,
   input  logic [4:0]    key_len,
   input  logic [63:0]   req_unix_seconds,
   input  logic [19:0]   req_code_value,
   input  logic          req_code_is_six_digits,
   output dp_status_type status
);

   logic [63:0]       quo_ff, quo_in;
   logic [4:0]        rem_ff, rem_in;
   logic              by_code_ff, by_code_in;
   logic [63:0]       step_ff, step_in;
   logic [63:0]       msg_ff, msg_in;
   logic [0:4][31:0]  h_ff, h_in;
   logic [31:0]       a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]       a_in, b_in, c_in, d_in, e_in;
   logic [0:15][31:0] w_ff, w_in;
   logic [159:0]      inner_ff, inner_in;
   logic [19:0]       code_ff, code_in;
   logic              six_ff, six_in;
   logic              match_ff, match_in;

   logic [12:0]       digit_val, digit_rem;
   logic [27:0]       digit_prod, fold_prod;
   logic [7:0]        digit_q;
   logic [31:0]       fold_val;
   logic [20:0]       code_mod;
   logic [159:0]      key_m, trunc_shift;
   logic [511:0]      block;
   logic [31:0]       f, t, w_new;
   logic [30:0]       trunc;

   // zero key bytes beyond the length in use
   for (genvar i = 0; i < STORED_KEY_BYTES; i++) begin : g_mask
      assign key_m[159-8*i -: 8] = (5'(i) < key_len) ? key_bytes[159-8*i -: 8] : 8'h00;
   end

   // one quotient byte per step: remainder below 30 joined with the next byte
   assign digit_val  = {rem_ff, quo_ff[63:56]};
   assign digit_prod = {15'd0, digit_val} * {12'd0, DIV_RECIP};
   assign digit_q    = digit_prod[27:20];
   assign digit_rem  = digit_val - ({5'd0, digit_q} * {8'd0, STEP_SECONDS});

   // fold bits above 2^20 back in, keeping the value modulo one million
   assign fold_prod = {16'd0, quo_ff[31:20]} * {12'd0, FOLD_WEIGHT};
   assign fold_val  = {4'd0, fold_prod} + {12'd0, quo_ff[19:0]};
   assign code_mod  = (quo_ff[20:0] >= CODE_MODULUS) ? quo_ff[20:0] - CODE_MODULUS
                                                      : quo_ff[20:0];

   assign w_new = {w_ff[13][30:0] ^ w_ff[8][30:0] ^ w_ff[2][30:0] ^ w_ff[0][30:0],
                   w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31]};

   always_comb begin
      case (cmd.phase)
         2'd0:    f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd2:    f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default: f = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + SHA1_K[cmd.phase] + w_ff[0];

   always_comb begin
      case (cmd.blk_sel)
         BLK_IPAD:   block = {key_m ^ {20{IPAD_BYTE}}, {44{IPAD_BYTE}}};
         BLK_MSG:    block = {msg_ff, PAD_MARK, 376'd0, MSG_BIT_LEN};
         BLK_OPAD:   block = {key_m ^ {20{OPAD_BYTE}}, {44{OPAD_BYTE}}};
         default:    block = {inner_ff, PAD_MARK, 280'd0, DIGEST_BIT_LEN};
      endcase
   end

   // dynamic truncation, offset from the low nibble of the last byte
   assign trunc_shift = h_ff << {h_ff[4][3:0], 3'b000};
   assign trunc       = trunc_shift[158:128];

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; by_code_in = by_code_ff;
      step_in = step_ff; msg_in = msg_ff; h_in = h_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      w_in = w_ff; inner_in = inner_ff;
      code_in = code_ff; six_in = six_ff; match_in = match_ff;
      if (cmd.capture) begin
         code_in = req_code_value;
         six_in = req_code_is_six_digits;
         match_in = 1'b0;
         quo_in = req_unix_seconds;
         rem_in = '0;
         by_code_in = 1'b0;
      end
      if (cmd.div_step) begin
         if (by_code_ff) begin
            quo_in = {32'd0, fold_val};
         end else begin
            rem_in = digit_rem[4:0];
            quo_in = {quo_ff[55:0], digit_q};
         end
      end
      if (cmd.save_step) step_in = quo_ff;
      if (cmd.set_msg) begin
         case (cmd.window)
            WIN_PREV: msg_in = step_ff - 64'd1;
            WIN_CUR:  msg_in = step_ff;
            default:  msg_in = step_ff + 64'd1;
         endcase
      end
      if (cmd.hash_init) h_in = SHA1_IV;
      if (cmd.load_block) begin
         w_in = block;
         a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3]; e_in = h_ff[4];
      end
      if (cmd.round) begin
         e_in = d_ff; d_in = c_ff; c_in = {b_ff[1:0], b_ff[31:2]}; b_in = a_ff; a_in = t;
         w_in = {w_ff[1:15], w_new};
      end
      if (cmd.finish) begin
         h_in = {h_ff[0] + a_ff, h_ff[1] + b_ff, h_ff[2] + c_ff, h_ff[3] + d_ff,
                 h_ff[4] + e_ff};
      end
      if (cmd.save_inner) inner_in = h_ff;
      if (cmd.load_trunc) begin
         quo_in = {33'd0, trunc};
         rem_in = '0;
         by_code_in = 1'b1;
      end
      if (cmd.check && (code_mod == {1'b0, code_ff})) match_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         six_ff   <= 1'b0;
      end else begin
         match_ff <= match_in;
         six_ff   <= six_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; by_code_ff <= by_code_in;
      step_ff <= step_in; msg_ff <= msg_in; h_ff <= h_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      w_ff <= w_in; inner_ff <= inner_in; code_ff <= code_in;
   end

   assign status.match      = match_ff;
   assign status.six_digits = six_ff;

endmodule

@@ hdl/totp_cv_ctrl.sv @@
// controller: sequences division, three hmac-sha1 runs and the compare
// depends on totp_cv_pkg
module totp_cv_ctrl
   import totp_cv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_code_accepted,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_TIME, ST_SAVE_STEP, ST_WIN_SET, ST_LOAD, ST_ROUNDS,
      ST_FINISH, ST_INNER, ST_TRUNC, ST_DIV_CODE, ST_CHECK, ST_DONE
   } state_type;

   state_type   state_ff;
   logic [6:0]  cnt_ff;
   logic [1:0]  win_ff;
   blk_sel_type blk_ff;
   logic        rsp_valid_ff, rsp_data_ff;
   logic        accept;

   assign req_ready         = (state_ff == ST_IDLE);
   assign accept            = req_valid && req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_accepted = rsp_data_ff;

   always_comb begin
      cmd            = '0;
      cmd.window     = win_ff;
      cmd.blk_sel    = blk_ff;
      cmd.capture    = accept;
      cmd.div_step   = (state_ff == ST_DIV_TIME) || (state_ff == ST_DIV_CODE);
      cmd.save_step  = (state_ff == ST_SAVE_STEP);
      cmd.set_msg    = (state_ff == ST_WIN_SET);
      cmd.hash_init  = (state_ff == ST_WIN_SET) || (state_ff == ST_INNER);
      cmd.load_block = (state_ff == ST_LOAD);
      cmd.round      = (state_ff == ST_ROUNDS);
      cmd.finish     = (state_ff == ST_FINISH);
      cmd.save_inner = (state_ff == ST_INNER);
      cmd.load_trunc = (state_ff == ST_TRUNC);
      cmd.check      = (state_ff == ST_CHECK);
      if (cnt_ff < 7'd20)      cmd.phase = 2'd0;
      else if (cnt_ff < 7'd40) cmd.phase = 2'd1;
      else if (cnt_ff < 7'd60) cmd.phase = 2'd2;
      else                     cmd.phase = 2'd3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         win_ff       <= WIN_PREV;
         blk_ff       <= BLK_IPAD;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) state_ff <= ST_DIV_TIME;
            end
            ST_DIV_TIME: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(TIME_DIGITS - 1)) state_ff <= ST_SAVE_STEP;
            end
            ST_SAVE_STEP: begin
               win_ff   <= WIN_PREV;
               state_ff <= ST_WIN_SET;
            end
            ST_WIN_SET: begin
               blk_ff   <= BLK_IPAD;
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               cnt_ff   <= '0;
               state_ff <= ST_ROUNDS;
            end
            ST_ROUNDS: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(SHA_ROUNDS - 1)) state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               case (blk_ff)
                  BLK_IPAD: begin
                     blk_ff   <= BLK_MSG;
                     state_ff <= ST_LOAD;
                  end
                  BLK_MSG:  state_ff <= ST_INNER;
                  BLK_OPAD: begin
                     blk_ff   <= BLK_DIGEST;
                     state_ff <= ST_LOAD;
                  end
                  default:  state_ff <= ST_TRUNC;
               endcase
            end
            ST_INNER: begin
               blk_ff   <= BLK_OPAD;
               state_ff <= ST_LOAD;
            end
            ST_TRUNC: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV_CODE;
            end
            ST_DIV_CODE: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(FOLD_STEPS - 1)) state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (win_ff == WIN_NEXT) begin
                  state_ff <= ST_DONE;
               end else begin
                  win_ff   <= win_ff + 2'd1;
                  state_ff <= ST_WIN_SET;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= status.match && status.six_digits;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ hdl/totp_code_verifier_top.sv @@
// totp code verifier, top level: key registers, controller and datapath
// depends on totp_cv_pkg, totp_cv_ctrl, totp_cv_datapath and the defines header
//
// checks a six-digit one-time code (hmac-sha1, 30 second steps) against the stored
// key, for the current step and the steps before and after it. one request is
// worked at a time: the next request is taken only once the result is offered.
// the seconds are divided by 30 a byte at a time and the step is saved; then for
// each of the three steps a setup state, four sha-1 compressions (one round per
// cycle on a single round engine), keeping the inner digest, truncation, folding
// the value modulo one million and a compare; a last state hands over the result.
// the result sits in an output register, so a new request is taken once the
// previous one is finished, even if its result has not been collected yet; if that
// result is still waiting when the next one is done, the block holds until it is
// collected. the key is to be written through the csr port by the user while the
// block is idle, which the block itself does not enforce; the length in use
// saturates at the smaller of MAX_KEY_BYTES and twenty bytes.
`include "totp_code_verifier_top_defines.svh"

module totp_code_verifier_top
   import totp_cv_pkg::*;
#(
   parameter int MAX_KEY_BYTES = 20
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_unix_seconds,
   input  logic [19:0] req_code_value,
   input  logic        req_code_is_six_digits,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_code_accepted,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // usable key bytes: the stored twenty, capped by the parameter
   localparam int KeyLimit = (MAX_KEY_BYTES < STORED_KEY_BYTES) ? MAX_KEY_BYTES
                                                                : STORED_KEY_BYTES;

   logic [63:0]   key_high_ff, key_middle_ff;
   logic [31:0]   key_low_ff;
   logic [4:0]    key_length_ff;
   logic [4:0]    key_len_eff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic [4:0]    dp_ops;
   logic          rsp_hold;

   // key registers, to be written by the user only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_middle_ff <= '0;
         key_low_ff    <= '0;
         key_length_ff <= KEY_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_HIGH:   key_high_ff   <= csr_wdata;
            CSR_KEY_MIDDLE: key_middle_ff <= csr_wdata;
            CSR_KEY_LOW:    key_low_ff    <= csr_wdata[31:0];
            CSR_KEY_LENGTH: key_length_ff <= csr_wdata[4:0];
            default:        key_length_ff <= key_length_ff;
         endcase
      end
   end

   // saturate the length in use
   assign key_len_eff = (key_length_ff > 5'(KeyLimit)) ? 5'(KeyLimit) : key_length_ff;

   // sequencer for one request
   totp_cv_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_accepted (rsp_code_accepted),
      .cmd               (cmd),
      .status            (status)
   );

   // divider, sha-1 engine and compare
   totp_cv_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .key_bytes              ({key_high_ff, key_middle_ff, key_low_ff}),
      .key_len                (key_len_eff),
      .req_unix_seconds       (req_unix_seconds),
      .req_code_value         (req_code_value),
      .req_code_is_six_digits (req_code_is_six_digits),
      .status                 (status)
   );

   // datapath operations that must never share a cycle
   assign dp_ops   = {cmd.div_step, cmd.round, cmd.load_block, cmd.finish, cmd.load_trunc};
   // result offered but not taken this cycle
   assign rsp_hold = rsp_valid && !rsp_ready;

   // a request keeps the block busy for at least the next cycle
   `TOTP_CV_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready while busy")
   // datapath operations never overlap
   `TOTP_CV_ASSERT_SAME(a_cmd_excl, 1'b1, $onehot0(dp_ops), "overlapping datapath commands")
   // a stalled result stays offered
   `TOTP_CV_ASSERT_NEXT(a_rsp_hold, rsp_hold, rsp_valid, "result dropped while stalled")
   // and keeps its value
   `TOTP_CV_ASSERT_NEXT(a_rsp_stable, rsp_hold, $stable(rsp_code_accepted), "result changed")

endmodule
